### rtl/core/i2cseq_pkg.sv
// Package for the I2C master transaction sequencer: command, event and
// acknowledge codes, reset values and the result record. No dependencies.
package i2cseq_pkg;

    localparam int BUF_DEPTH_DEF = 16;

    localparam logic [2:0] MAX_RETRIES_RST = 3'd2;
    localparam logic [4:0] MAX_BYTES       = 5'd16;
    localparam logic [3:0] RETRY_SAT       = 4'd15;

    localparam logic [1:0] CMD_LOAD        = 2'd0;
    localparam logic [1:0] CMD_START_WRITE = 2'd1;
    localparam logic [1:0] CMD_START_READ  = 2'd2;
    localparam logic [1:0] CMD_EVENT       = 2'd3;

    localparam logic [3:0] EV_START        = 4'd0;
    localparam logic [3:0] EV_REP_START    = 4'd1;
    localparam logic [3:0] EV_MT_SLA_ACK   = 4'd2;
    localparam logic [3:0] EV_MT_SLA_NACK  = 4'd3;
    localparam logic [3:0] EV_MT_DATA_ACK  = 4'd4;
    localparam logic [3:0] EV_MT_DATA_NACK = 4'd5;
    localparam logic [3:0] EV_MR_SLA_ACK   = 4'd6;
    localparam logic [3:0] EV_MR_SLA_NACK  = 4'd7;
    localparam logic [3:0] EV_MR_DATA_ACK  = 4'd8;
    localparam logic [3:0] EV_MR_DATA_NACK = 4'd9;

    localparam logic [1:0] ACK_KEEP  = 2'd0;
    localparam logic [1:0] ACK_SET   = 2'd1;
    localparam logic [1:0] ACK_CLEAR = 2'd2;

    typedef struct packed {
        logic       rejected;
        logic       send_start;
        logic       send_stop;
        logic       int_clear;
        logic [1:0] ack_mode;
        logic       data_load;
        logic [7:0] data_out;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic       busy_res;
    } res_t;

endpackage

### rtl/core/i2cseq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module i2cseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/i2c_master_transaction_sequencer.sv
// Top level of the I2C master transaction sequencer.
// Depends on i2cseq_pkg and i2cseq_ram (transmit buffer).
//
//  Channel | Direction | Handshake            | Payload
//  s_      | in        | s_valid / s_ready    | command, buffer write, start, bus event
//  m_      | out       | m_valid / m_ready    | bus actions, received byte, busy
//  cfg_    | in        | cfg_valid / cfg_ready| max_retries
//
// One command is accepted per cycle unless the result stalls; it passes through the
// input register, then the result register. The transmit buffer RAM is read ahead
// at the byte position left by the previous item, so one item per cycle is sustained
// without stalls. Reset is synchronous and active low; the buffer is not cleared.
// A stalled result register holds back the input register and then s_ready.
module i2c_master_transaction_sequencer
    import i2cseq_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUF_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [3:0] s_buf_index,
    input  logic [7:0] s_buf_byte,
    input  logic [6:0] s_slave_address,
    input  logic [4:0] s_byte_count,
    input  logic [3:0] s_event_code,
    input  logic [7:0] s_rx_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_rejected,
    output logic       m_send_start,
    output logic       m_send_stop,
    output logic       m_int_clear,
    output logic [1:0] m_ack_mode,
    output logic       m_data_load,
    output logic [7:0] m_data_out,
    output logic       m_rx_valid,
    output logic [3:0] m_rx_index,
    output logic [7:0] m_rx_byte,
    output logic       m_busy_res,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_max_retries
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic       in_valid_reg;
    logic [1:0] cmd_reg;
    logic [3:0] buf_index_reg;
    logic [7:0] buf_byte_reg;
    logic [6:0] slave_address_reg;
    logic [4:0] byte_count_reg;
    logic [3:0] event_code_reg;
    logic [7:0] rx_data_reg;

    logic       advance;
    logic       m_valid_reg;
    res_t       res_reg;
    res_t       res_next;

    logic [2:0] max_retries_reg;
    logic       busy_reg, busy_next;
    logic       read_dir_reg, read_dir_next;
    logic [6:0] target_reg, target_next;
    logic [4:0] bytes_left_reg, bytes_left_next;
    logic [3:0] retry_reg, retry_next;
    logic [3:0] position_reg, position_next;

    logic          wr_en;
    logic [8:0]    wr_index_wide;
    logic [8:0]    rd_index_wide;
    logic [7:0]    rd_data;
    logic          rd_ok_reg;
    logic [7:0]    tx_byte;
    logic [4:0]    count_clamped;
    logic          more_left;
    logic [4:0]    bytes_down;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg           <= s_cmd;
            buf_index_reg     <= s_buf_index;
            buf_byte_reg      <= s_buf_byte;
            slave_address_reg <= s_slave_address;
            byte_count_reg    <= s_byte_count;
            event_code_reg    <= s_event_code;
            rx_data_reg       <= s_rx_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg <= MAX_RETRIES_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_retries_reg <= cfg_max_retries;
        end
    end

    assign wr_index_wide = {5'd0, buf_index_reg};
    assign rd_index_wide = {5'd0, position_next};

    i2cseq_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_buf (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_index_wide[AW-1:0]),
        .wdata (buf_byte_reg),
        .raddr (rd_index_wide[AW-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        rd_ok_reg <= rd_index_wide < 9'(BUFFER_DEPTH);
    end

    assign tx_byte = rd_ok_reg ? rd_data : 8'd0;

    assign more_left  = bytes_left_reg > 5'd1;
    assign bytes_down = more_left ? bytes_left_reg - 5'd1 : 5'd0;

    always_comb begin
        if (byte_count_reg == 5'd0) begin
            count_clamped = 5'd1;
        end else if (byte_count_reg > MAX_BYTES) begin
            count_clamped = MAX_BYTES;
        end else begin
            count_clamped = byte_count_reg;
        end
    end

    always_comb begin
        res_next        = '0;
        wr_en           = 1'b0;
        busy_next       = busy_reg;
        read_dir_next   = read_dir_reg;
        target_next     = target_reg;
        bytes_left_next = bytes_left_reg;
        retry_next      = retry_reg;
        position_next   = position_reg;

        if (advance) begin
            unique case (cmd_reg)
                CMD_LOAD: begin
                    if (busy_reg) begin
                        res_next.rejected = 1'b1;
                    end else begin
                        wr_en = wr_index_wide < 9'(BUFFER_DEPTH);
                    end
                end
                CMD_START_WRITE, CMD_START_READ: begin
                    if (busy_reg) begin
                        res_next.rejected = 1'b1;
                    end else begin
                        target_next         = slave_address_reg;
                        bytes_left_next     = count_clamped;
                        read_dir_next       = cmd_reg == CMD_START_READ;
                        retry_next          = 4'd0;
                        position_next       = 4'd0;
                        busy_next           = 1'b1;
                        res_next.send_start = 1'b1;
                        res_next.int_clear  = 1'b1;
                    end
                end
                CMD_EVENT: begin
                    if (busy_reg) begin
                        unique case (event_code_reg)
                            EV_START, EV_REP_START: begin
                                res_next.int_clear = 1'b1;
                                if (retry_reg > {1'b0, max_retries_reg}) begin
                                    res_next.send_stop = 1'b1;
                                    busy_next          = 1'b0;
                                end else begin
                                    res_next.data_out  = {target_reg, read_dir_reg};
                                    res_next.data_load = 1'b1;
                                end
                            end
                            EV_MT_SLA_ACK: begin
                                retry_next         = 4'd0;
                                res_next.data_out  = tx_byte;
                                res_next.data_load = 1'b1;
                                res_next.int_clear = 1'b1;
                                position_next      = position_reg + 4'd1;
                            end
                            EV_MT_SLA_NACK, EV_MR_SLA_NACK: begin
                                if (retry_reg != RETRY_SAT) begin
                                    retry_next = retry_reg + 4'd1;
                                end
                                res_next.send_start = 1'b1;
                                res_next.send_stop  = 1'b1;
                                res_next.int_clear  = 1'b1;
                            end
                            EV_MT_DATA_ACK: begin
                                bytes_left_next    = bytes_down;
                                res_next.int_clear = 1'b1;
                                if (more_left) begin
                                    res_next.data_out  = tx_byte;
                                    res_next.data_load = 1'b1;
                                    position_next      = position_reg + 4'd1;
                                end else begin
                                    res_next.send_stop = 1'b1;
                                    busy_next          = 1'b0;
                                end
                            end
                            EV_MT_DATA_NACK: begin
                                res_next.send_stop = 1'b1;
                                res_next.int_clear = 1'b1;
                                busy_next          = 1'b0;
                            end
                            EV_MR_SLA_ACK: begin
                                bytes_left_next    = bytes_down;
                                res_next.ack_mode  = more_left ? ACK_SET : ACK_KEEP;
                                res_next.int_clear = 1'b1;
                            end
                            EV_MR_DATA_ACK: begin
                                res_next.rx_valid  = 1'b1;
                                res_next.rx_index  = position_reg;
                                res_next.rx_byte   = rx_data_reg;
                                position_next      = position_reg + 4'd1;
                                bytes_left_next    = bytes_down;
                                res_next.ack_mode  = more_left ? ACK_SET : ACK_CLEAR;
                                res_next.int_clear = 1'b1;
                            end
                            EV_MR_DATA_NACK: begin
                                res_next.rx_valid  = 1'b1;
                                res_next.rx_index  = position_reg;
                                res_next.rx_byte   = rx_data_reg;
                                position_next      = position_reg + 4'd1;
                                res_next.send_stop = 1'b1;
                                res_next.int_clear = 1'b1;
                                busy_next          = 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
        end

        res_next.busy_res = busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            read_dir_reg   <= 1'b0;
            target_reg     <= 7'd0;
            bytes_left_reg <= 5'd0;
            retry_reg      <= 4'd0;
            position_reg   <= 4'd0;
        end else begin
            busy_reg       <= busy_next;
            read_dir_reg   <= read_dir_next;
            target_reg     <= target_next;
            bytes_left_reg <= bytes_left_next;
            retry_reg      <= retry_next;
            position_reg   <= position_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rejected   = res_reg.rejected;
    assign m_send_start = res_reg.send_start;
    assign m_send_stop  = res_reg.send_stop;
    assign m_int_clear  = res_reg.int_clear;
    assign m_ack_mode   = res_reg.ack_mode;
    assign m_data_load  = res_reg.data_load;
    assign m_data_out   = res_reg.data_out;
    assign m_rx_valid   = res_reg.rx_valid;
    assign m_rx_index   = res_reg.rx_index;
    assign m_rx_byte    = res_reg.rx_byte;
    assign m_busy_res   = res_reg.busy_res;

endmodule

### rtl/core/i2cseq_checker.sv
// Port-level checks for the I2C master transaction sequencer, with the bind
// that attaches them to the top level. Depends on i2cseq_pkg.
module i2cseq_checker
    import i2cseq_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_rejected,
    input logic       m_send_start,
    input logic       m_send_stop,
    input logic       m_int_clear,
    input logic [1:0] m_ack_mode,
    input logic       m_data_load,
    input logic [7:0] m_data_out,
    input logic       m_rx_valid,
    input logic [3:0] m_rx_index,
    input logic [7:0] m_rx_byte,
    input logic       m_busy_res
);

    // A stalled result keeps its valid, its data_out and rx_byte fields and its busy flag.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_rx_byte)
            && $stable(m_busy_res))
        else $error("result changed while stalled");

    // A rejected command takes no bus action and leaves the transfer running.
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> !m_send_start && !m_send_stop && !m_int_clear
            && !m_data_load && !m_rx_valid && m_busy_res)
        else $error("rejected command produced bus actions");

    // Received byte fields are zero unless a byte is reported.
    a_rx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rx_valid |-> m_rx_index == 4'd0 && m_rx_byte == 8'd0)
        else $error("received byte fields set without rx_valid");

    // Any acknowledge change, received byte or data load comes with an interrupt clear.
    a_ack_intc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_ack_mode != ACK_KEEP || m_rx_valid || m_data_load)
            |-> m_int_clear && m_ack_mode != 2'd3)
        else $error("bus action without interrupt clear");

endmodule

bind i2c_master_transaction_sequencer i2cseq_checker u_i2cseq_checker (.*);

### sim/i2c_master_transaction_sequencer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_transaction_sequencer: directed and random
// command and bus event traffic, checked against a bus action predictor.
// Depends on i2cseq_pkg and the sequencer RTL.
module i2c_master_transaction_sequencer_test;
    import i2cseq_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int LATENCY         = 2;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int PHASES          = 6;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [3:0] EV_UNKNOWN_LO = 4'd10;
    localparam logic [3:0] EV_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] buf_index;
        logic [7:0] buf_byte;
        logic [6:0] slave_address;
        logic [4:0] byte_count;
        logic [3:0] event_code;
        logic [7:0] rx_data;
    } seq_item_t;

    class bus_action_board;
        logic       busy;
        logic       rd_dir;
        logic [6:0] target;
        logic [4:0] left;
        logic [3:0] retries;
        logic [3:0] pos;
        logic [2:0] max_retries;
        logic [7:0] txbuf [BUF_DEPTH_DEF];
        bit         written [BUF_DEPTH_DEF];
        res_t       expected_actions [$];
        int         failures;

        function new();
            busy = 1'b0;
            rd_dir = 1'b0;
            target = '0;
            left = '0;
            retries = '0;
            pos = '0;
            max_retries = MAX_RETRIES_RST;
            foreach (written[i]) written[i] = 1'b0;
            failures = 0;
        endfunction

        function bit reads_unwritten(seq_item_t it);
            if (it.cmd != CMD_EVENT || !busy)
                return 1'b0;
            if (it.event_code == EV_MT_SLA_ACK ||
                    (it.event_code == EV_MT_DATA_ACK && left > 5'd1))
                return !written[pos];
            return 1'b0;
        endfunction

        function bit step_down();
            if (left <= 5'd1) begin
                left = 5'd0;
                return 1'b0;
            end
            left = left - 5'd1;
            return 1'b1;
        endfunction

        function void send_byte(inout res_t r);
            r.data_out = txbuf[pos];
            r.data_load = 1'b1;
            r.int_clear = 1'b1;
            pos = pos + 4'd1;
        endfunction

        function void take_byte(inout res_t r, input logic [7:0] rx);
            r.rx_valid = 1'b1;
            r.rx_index = pos;
            r.rx_byte = rx;
            pos = pos + 4'd1;
        endfunction

        function void end_transfer(inout res_t r);
            r.send_stop = 1'b1;
            r.int_clear = 1'b1;
            busy = 1'b0;
        endfunction

        function res_t predict_actions(seq_item_t it);
            res_t       r;
            logic [4:0] cnt;
            r = '0;
            case (it.cmd)
                CMD_LOAD: begin
                    if (busy) begin
                        r.rejected = 1'b1;
                    end else begin
                        txbuf[it.buf_index] = it.buf_byte;
                        written[it.buf_index] = 1'b1;
                    end
                end
                CMD_START_WRITE, CMD_START_READ: begin
                    if (busy) begin
                        r.rejected = 1'b1;
                    end else begin
                        cnt = it.byte_count;
                        if (cnt == 5'd0)
                            cnt = 5'd1;
                        if (cnt > MAX_BYTES)
                            cnt = MAX_BYTES;
                        target = it.slave_address;
                        left = cnt;
                        rd_dir = (it.cmd == CMD_START_READ);
                        retries = '0;
                        pos = '0;
                        busy = 1'b1;
                        r.send_start = 1'b1;
                        r.int_clear = 1'b1;
                    end
                end
                default: begin
                    if (busy) begin
                        case (it.event_code)
                            EV_START, EV_REP_START: begin
                                if (retries > {1'b0, max_retries}) begin
                                    end_transfer(r);
                                end else begin
                                    r.data_out = {target, rd_dir};
                                    r.data_load = 1'b1;
                                    r.int_clear = 1'b1;
                                end
                            end
                            EV_MT_SLA_ACK: begin
                                retries = '0;
                                send_byte(r);
                            end
                            EV_MT_SLA_NACK, EV_MR_SLA_NACK: begin
                                if (retries != RETRY_SAT)
                                    retries = retries + 4'd1;
                                r.send_start = 1'b1;
                                r.send_stop = 1'b1;
                                r.int_clear = 1'b1;
                            end
                            EV_MT_DATA_ACK: begin
                                if (step_down())
                                    send_byte(r);
                                else
                                    end_transfer(r);
                            end
                            EV_MT_DATA_NACK: begin
                                end_transfer(r);
                            end
                            EV_MR_SLA_ACK: begin
                                if (step_down())
                                    r.ack_mode = ACK_SET;
                                r.int_clear = 1'b1;
                            end
                            EV_MR_DATA_ACK: begin
                                take_byte(r, it.rx_data);
                                r.ack_mode = step_down() ? ACK_SET : ACK_CLEAR;
                                r.int_clear = 1'b1;
                            end
                            EV_MR_DATA_NACK: begin
                                take_byte(r, it.rx_data);
                                end_transfer(r);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
            r.busy_res = busy;
            return r;
        endfunction

        function void note_command(seq_item_t it);
            expected_actions.push_back(predict_actions(it));
        endfunction

        function string show(res_t r);
            return $sformatf({"rej=%0d start=%0d stop=%0d intc=%0d ack=%0d load=%0d ",
                              "dout=%02h rxv=%0d rxi=%0d rxb=%02h busy=%0d"},
                             r.rejected, r.send_start, r.send_stop, r.int_clear,
                             r.ack_mode, r.data_load, r.data_out, r.rx_valid,
                             r.rx_index, r.rx_byte, r.busy_res);
        endfunction

        function void log_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_actions(res_t got);
            res_t  want;
            string diff;
            if (expected_actions.size() == 0) begin
                log_failure($sformatf("%0t: result with nothing expected: %s",
                                      $time, show(got)));
            end else begin
                want = expected_actions.pop_front();
                diff = "";
                if (got.rejected !== want.rejected) diff = {diff, " rejected"};
                if (got.send_start !== want.send_start) diff = {diff, " send_start"};
                if (got.send_stop !== want.send_stop) diff = {diff, " send_stop"};
                if (got.int_clear !== want.int_clear) diff = {diff, " int_clear"};
                if (got.ack_mode !== want.ack_mode) diff = {diff, " ack_mode"};
                if (got.data_load !== want.data_load) diff = {diff, " data_load"};
                if (got.data_out !== want.data_out) diff = {diff, " data_out"};
                if (got.rx_valid !== want.rx_valid) diff = {diff, " rx_valid"};
                if (got.rx_index !== want.rx_index) diff = {diff, " rx_index"};
                if (got.rx_byte !== want.rx_byte) diff = {diff, " rx_byte"};
                if (got.busy_res !== want.busy_res) diff = {diff, " busy_res"};
                if (diff != "")
                    log_failure($sformatf("%0t: mismatch in%s\n  expected %s\n  actual   %s",
                                          $time, diff, show(want), show(got)));
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd = CMD_LOAD;
    logic [3:0] s_buf_index = '0;
    logic [7:0] s_buf_byte = '0;
    logic [6:0] s_slave_address = '0;
    logic [4:0] s_byte_count = '0;
    logic [3:0] s_event_code = EV_START;
    logic [7:0] s_rx_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_rejected;
    logic       m_send_start;
    logic       m_send_stop;
    logic       m_int_clear;
    logic [1:0] m_ack_mode;
    logic       m_data_load;
    logic [7:0] m_data_out;
    logic       m_rx_valid;
    logic [3:0] m_rx_index;
    logic [7:0] m_rx_byte;
    logic       m_busy_res;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_max_retries = MAX_RETRIES_RST;

    bus_action_board board;
    int burst_left = 0;
    int gap_max = 0;
    int stall_mode = 0;
    int counted_items = 0;
    int cycle_count = 0;

    i2c_master_transaction_sequencer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_buf_index    (s_buf_index),
        .s_buf_byte     (s_buf_byte),
        .s_slave_address(s_slave_address),
        .s_byte_count   (s_byte_count),
        .s_event_code   (s_event_code),
        .s_rx_data      (s_rx_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rejected     (m_rejected),
        .m_send_start   (m_send_start),
        .m_send_stop    (m_send_stop),
        .m_int_clear    (m_int_clear),
        .m_ack_mode     (m_ack_mode),
        .m_data_load    (m_data_load),
        .m_data_out     (m_data_out),
        .m_rx_valid     (m_rx_valid),
        .m_rx_index     (m_rx_index),
        .m_rx_byte      (m_rx_byte),
        .m_busy_res     (m_busy_res),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_max_retries(cfg_max_retries)
    );

    always #5 aclk = ~aclk;

    function automatic seq_item_t random_item();
        seq_item_t it;
        it.cmd = 2'($urandom_range(0, 3));
        it.buf_index = 4'($urandom());
        it.buf_byte = 8'($urandom());
        it.slave_address = 7'($urandom());
        it.byte_count = 5'($urandom());
        it.event_code = 4'($urandom());
        it.rx_data = 8'($urandom());
        return it;
    endfunction

    task automatic push_item(input seq_item_t it);
        // An unwritten buffer entry must never be shifted out; end the transfer instead.
        if (board.reads_unwritten(it))
            it.event_code = EV_MT_DATA_NACK;
        s_valid <= 1'b1;
        s_cmd <= it.cmd;
        s_buf_index <= it.buf_index;
        s_buf_byte <= it.buf_byte;
        s_slave_address <= it.slave_address;
        s_byte_count <= it.byte_count;
        s_event_code <= it.event_code;
        s_rx_data <= it.rx_data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!(it.cmd == CMD_EVENT && (!board.busy || it.event_code >= EV_UNKNOWN_LO)))
            counted_items++;
        board.note_command(it);
        if (gap_max > 0 && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic issue(input logic [1:0] cmd, input logic [3:0] code, input logic [7:0] data);
        seq_item_t it;
        it = random_item();
        it.cmd = cmd;
        if (cmd == CMD_LOAD) begin
            it.buf_index = code;
            it.buf_byte = data;
        end else begin
            it.event_code = code;
            it.rx_data = data;
        end
        push_item(it);
    endtask

    task automatic start_transfer(input logic [1:0] cmd, input logic [4:0] cnt,
                                  input logic [6:0] addr);
        seq_item_t it;
        it = random_item();
        it.cmd = cmd;
        it.byte_count = cnt;
        it.slave_address = addr;
        push_item(it);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 15) == 0)
            push_item(random_item());
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.expected_actions.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic run_transfer(input bit is_read);
        logic [4:0] cnt;
        logic [3:0] nack_code;
        int         eff;
        int         nacks;
        case ($urandom_range(0, 9))
            0: cnt = 5'($urandom_range(5, 16));
            1: cnt = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
            default: cnt = 5'($urandom_range(1, 4));
        endcase
        eff = (cnt == 5'd0) ? 1 : (cnt > MAX_BYTES) ? int'(MAX_BYTES) : int'(cnt);
        nack_code = is_read ? EV_MR_SLA_NACK : EV_MT_SLA_NACK;
        while (board.busy)
            issue(CMD_EVENT, EV_MT_DATA_NACK, 8'($urandom()));
        if (!is_read) begin
            for (int i = 0; i < eff; i++) begin
                if (!board.written[i] || $urandom_range(0, 3) != 0)
                    issue(CMD_LOAD, 4'(i), 8'($urandom()));
                maybe_noise();
            end
        end
        start_transfer(is_read ? CMD_START_READ : CMD_START_WRITE, cnt, 7'($urandom()));
        issue(CMD_EVENT, EV_START, 8'($urandom()));
        if ($urandom_range(0, 15) == 0)
            repeat (17) issue(CMD_EVENT, nack_code, 8'($urandom()));
        nacks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, board.max_retries + 2) : 0;
        for (int k = 0; k < nacks && board.busy; k++) begin
            issue(CMD_EVENT, nack_code, 8'($urandom()));
            maybe_noise();
            issue(CMD_EVENT, ($urandom_range(0, 1) != 0) ? EV_REP_START : EV_START,
                  8'($urandom()));
        end
        if (board.busy) begin
            if (is_read) begin
                issue(CMD_EVENT, EV_MR_SLA_ACK, 8'($urandom()));
                for (int i = 1; i < eff && board.busy; i++) begin
                    maybe_noise();
                    issue(CMD_EVENT, EV_MR_DATA_ACK, 8'($urandom()));
                end
                issue(CMD_EVENT, EV_MR_DATA_NACK, 8'($urandom()));
            end else begin
                issue(CMD_EVENT, EV_MT_SLA_ACK, 8'($urandom()));
                for (int i = 0; i < eff && board.busy; i++) begin
                    maybe_noise();
                    issue(CMD_EVENT, ($urandom_range(0, 15) == 0) ? EV_MT_DATA_NACK
                                                                  : EV_MT_DATA_ACK,
                          8'($urandom()));
                end
            end
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        logic [15:0] pattern;
        int          refresh;
        if (aresetn && m_valid && m_ready)
            board.check_actions(res_t'{rejected: m_rejected, send_start: m_send_start,
                                       send_stop: m_send_stop, int_clear: m_int_clear,
                                       ack_mode: m_ack_mode, data_load: m_data_load,
                                       data_out: m_data_out, rx_valid: m_rx_valid,
                                       rx_index: m_rx_index, rx_byte: m_rx_byte,
                                       busy_res: m_busy_res});
        if (stall_mode == 0) begin
            m_ready <= 1'b1;
        end else begin
            if (refresh <= 0) begin
                pattern = 16'($urandom()) | 16'h0001;
                refresh = $urandom_range(16, 160);
            end
            refresh--;
            m_ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [2:0] setting;
        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        stall_mode = 1;
        gap_max = 3;

        issue(CMD_EVENT, EV_START, 8'h00);
        issue(CMD_LOAD, 4'd0, 8'h00);
        issue(CMD_LOAD, 4'd15, 8'hFF);
        issue(CMD_LOAD, 4'd1, 8'hA5);
        start_transfer(CMD_START_WRITE, 5'd0, 7'h7F);
        issue(CMD_EVENT, EV_START, 8'hFF);
        issue(CMD_EVENT, EV_MT_SLA_ACK, 8'h00);
        issue(CMD_EVENT, EV_UNKNOWN_LO, 8'h00);
        issue(CMD_LOAD, 4'd2, 8'h5A);
        start_transfer(CMD_START_READ, 5'd5, 7'h00);
        issue(CMD_EVENT, EV_MT_DATA_ACK, 8'h00);
        start_transfer(CMD_START_READ, 5'd31, 7'h00);
        issue(CMD_EVENT, EV_START, 8'h00);
        issue(CMD_EVENT, EV_MR_SLA_NACK, 8'h00);
        issue(CMD_EVENT, EV_REP_START, 8'h00);
        issue(CMD_EVENT, EV_MR_SLA_NACK, 8'h00);
        issue(CMD_EVENT, EV_MT_SLA_NACK, 8'h00);
        issue(CMD_EVENT, EV_START, 8'h00);
        start_transfer(CMD_START_READ, 5'd1, 7'h2A);
        issue(CMD_EVENT, EV_START, 8'h00);
        issue(CMD_EVENT, EV_MR_SLA_ACK, 8'h00);
        issue(CMD_EVENT, EV_MR_DATA_ACK, 8'hFF);
        issue(CMD_EVENT, EV_MR_DATA_NACK, 8'h00);
        issue(CMD_EVENT, EV_UNKNOWN_HI, 8'hFF);

        counted_items = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1: setting = 3'd0;
                    2: setting = 3'd7;
                    4: setting = 3'd1;
                    default: setting = 3'($urandom());
                endcase
                cfg_max_retries <= setting;
                cfg_valid <= 1'b1;
                @(posedge aclk);
                while (!cfg_ready) @(posedge aclk);
                cfg_valid <= 1'b0;
                board.max_retries = setting;
            end
            gap_max = (phase == 2) ? 0 : $urandom_range(1, 6);
            stall_mode = (phase == 2 || phase == 4) ? 0 : 1;
            while (counted_items < (phase + 1) * ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 7)
                    run_transfer(1'($urandom_range(0, 1)));
                else
                    repeat ($urandom_range(1, 6)) push_item(random_item());
            end
        end

        drain_results();
        if (board.failures == 0 && board.expected_actions.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
